>>> rtl/cpcr_pkg.sv
// shared types and constants for the circle pair collision response block
// no dependencies
package cpcr_pkg;

  localparam int POS_W         = 32;
  localparam int RAD_W         = 31;
  localparam int MASS_W        = 32;
  localparam int SUM_W         = 32;   // sum of two radii
  localparam int TOTAL_W       = 33;   // sum of two masses
  localparam int DIST2_W       = 64;
  localparam int ROOT_W        = 32;
  localparam int GAIN_W        = 17;
  localparam int MOVE_W        = 32;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd49152;

  localparam logic [1:0] STATUS_NONE  = 2'd0;
  localparam logic [1:0] STATUS_HIT   = 2'd1;
  localparam logic [1:0] STATUS_DEGEN = 2'd2;

  typedef struct packed {
    logic       dx_neg;
    logic       dx_pos;
    logic       dy_neg;
    logic       dy_pos;
    logic [1:0] status;
  } cpcr_flags_t;

  // travels with the radicand through the square root
  typedef struct packed {
    logic [ROOT_W-1:0]  mx;
    logic [ROOT_W-1:0]  my;
    logic [SUM_W-1:0]   minr;
    logic [MASS_W-1:0]  mb;
    logic [TOTAL_W-1:0] total;
    cpcr_flags_t        flags;
  } cpcr_front_t;

  // travels with the quotients through the divider
  typedef struct packed {
    logic [SUM_W-1:0]  minr;
    logic [ROOT_W-1:0] distance;
    cpcr_flags_t       flags;
  } cpcr_mid_t;

endpackage

>>> rtl/circle_pair_collision_response_top.sv
// pipeline: 3 front stages, 32 square root stages (one root bit each), FRAC_BITS + 1
// divider stages, 3 back stages; throughput: one word per cycle while out_ready is high;
// every stage holds its own valid bit, so bubbles close up and input is taken while a
// finished word waits at the output, as long as some stage is still empty
// reset: synchronous, clears all valid bits and sets the gain to 0.375 (gain / 2^17)
module circle_pair_collision_response_top #(
  parameter int FRAC_BITS = cpcr_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // gain register
  input  logic                                 cfg_we,
  input  logic [cpcr_pkg::GAIN_W-1:0]          cfg_data,
  // input words
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [cpcr_pkg::POS_W-1:0]    pos_a_x,
  input  logic signed [cpcr_pkg::POS_W-1:0]    pos_a_y,
  input  logic signed [cpcr_pkg::POS_W-1:0]    pos_b_x,
  input  logic signed [cpcr_pkg::POS_W-1:0]    pos_b_y,
  input  logic [cpcr_pkg::RAD_W-1:0]           radius_a,
  input  logic [cpcr_pkg::RAD_W-1:0]           radius_b,
  input  logic [cpcr_pkg::MASS_W-1:0]          mass_a,
  input  logic [cpcr_pkg::MASS_W-1:0]          mass_b,
  // result words
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [cpcr_pkg::MOVE_W-1:0]   move_a_x,
  output logic signed [cpcr_pkg::MOVE_W-1:0]   move_a_y,
  output logic signed [cpcr_pkg::MOVE_W-1:0]   move_b_x,
  output logic signed [cpcr_pkg::MOVE_W-1:0]   move_b_y,
  output logic [1:0]                           contact_status
);
  import cpcr_pkg::*;

  localparam int QW    = FRAC_BITS + 1;
  localparam int NUM_W = ROOT_W + FRAC_BITS;
  localparam int D_W   = POS_W + 1;

  // response gain; the user must write it only while the pipe is empty (not enforced)
  logic [GAIN_W-1:0] gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_we) begin
      gain <= cfg_data;
    end
  end

  // front: three stages with their own ready chain
  logic [2:0] fv;
  logic [2:0] frdy;
  logic       sq_in_ready;

  assign frdy[2] = !fv[2] || sq_in_ready;
  assign frdy[1] = !fv[1] || frdy[2];
  assign frdy[0] = !fv[0] || frdy[1];
  assign in_ready = frdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else begin
      if (frdy[0]) fv[0] <= in_valid;
      if (frdy[1]) fv[1] <= fv[0];
      if (frdy[2]) fv[2] <= fv[1];
    end
  end

  // stage f1: center differences as magnitude and sign, radius and mass sums
  logic signed [D_W-1:0] dx, dy;
  logic [ROOT_W-1:0]     mx1, my1;
  logic [SUM_W-1:0]      minr1;
  logic [MASS_W-1:0]     mb1;
  logic [TOTAL_W-1:0]    total1;
  logic [3:0]            sgn1;

  assign dx = D_W'(pos_a_x) - D_W'(pos_b_x);
  assign dy = D_W'(pos_a_y) - D_W'(pos_b_y);

  always_ff @(posedge clk) begin
    if (frdy[0]) begin
      mx1    <= dx[D_W-1] ? ROOT_W'(-dx) : ROOT_W'(dx);
      my1    <= dy[D_W-1] ? ROOT_W'(-dy) : ROOT_W'(dy);
      sgn1   <= {dx[D_W-1], !dx[D_W-1] && (dx != '0),
                 dy[D_W-1], !dy[D_W-1] && (dy != '0)};
      minr1  <= SUM_W'(radius_a) + SUM_W'(radius_b);
      mb1    <= mass_b;
      total1 <= TOTAL_W'(mass_a) + TOTAL_W'(mass_b);
    end
  end

  // stage f2: squares
  logic [DIST2_W-1:0] sx2, sy2, min2_2;
  logic [ROOT_W-1:0]  mx2, my2;
  logic [SUM_W-1:0]   minr2;
  logic [MASS_W-1:0]  mb2;
  logic [TOTAL_W-1:0] total2;
  logic [3:0]         sgn2;

  always_ff @(posedge clk) begin
    if (frdy[1]) begin
      sx2    <= DIST2_W'(mx1) * DIST2_W'(mx1);
      sy2    <= DIST2_W'(my1) * DIST2_W'(my1);
      min2_2 <= DIST2_W'(minr1) * DIST2_W'(minr1);
      mx2    <= mx1;
      my2    <= my1;
      minr2  <= minr1;
      mb2    <= mb1;
      total2 <= total1;
      sgn2   <= sgn1;
    end
  end

  // stage f3: overlap test on the exact sum, carry past 64 bits never overlaps
  logic [DIST2_W:0]   dist2;
  logic               overlap;
  logic               degen;
  logic [DIST2_W-1:0] rad3;
  cpcr_front_t        front3;

  assign dist2   = {1'b0, sx2} + {1'b0, sy2};
  assign overlap = dist2 < {1'b0, min2_2};
  assign degen   = (dist2 == '0) || (total2 == '0);

  always_ff @(posedge clk) begin
    if (frdy[2]) begin
      rad3                <= dist2[DIST2_W-1:0];
      front3.mx           <= mx2;
      front3.my           <= my2;
      front3.minr         <= minr2;
      front3.mb           <= mb2;
      front3.total        <= total2;
      front3.flags.dx_neg <= sgn2[3];
      front3.flags.dx_pos <= sgn2[2];
      front3.flags.dy_neg <= sgn2[1];
      front3.flags.dy_pos <= sgn2[0];
      front3.flags.status <= !overlap ? STATUS_NONE : (degen ? STATUS_DEGEN : STATUS_HIT);
    end
  end

  // distance by square root
  logic                          sq_valid, dv_in_ready;
  logic [ROOT_W-1:0]             distance;
  logic [$bits(cpcr_front_t)-1:0] sq_side;
  cpcr_front_t                   fr;

  cpcr_sqrt #(
    .SW ($bits(cpcr_front_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fv[2]),
    .in_ready  (sq_in_ready),
    .in_rad    (rad3),
    .in_side   (front3),
    .out_valid (sq_valid),
    .out_ready (dv_in_ready),
    .out_root  (distance),
    .out_side  (sq_side)
  );

  assign fr = cpcr_front_t'(sq_side);

  // unit normal in two lanes and mass share in the third
  logic [NUM_W-1:0]   num [3];
  logic [TOTAL_W-1:0] den [3];
  logic [QW-1:0]      quo [3];
  cpcr_mid_t          mid_in;
  logic [$bits(cpcr_mid_t)-1:0] mid_out;
  logic               dv_valid, bk_in_ready;

  assign num[0] = {fr.mx, {FRAC_BITS{1'b0}}};
  assign num[1] = {fr.my, {FRAC_BITS{1'b0}}};
  assign num[2] = {fr.mb, {FRAC_BITS{1'b0}}};
  assign den[0] = TOTAL_W'(distance);
  assign den[1] = TOTAL_W'(distance);
  assign den[2] = fr.total;

  assign mid_in.minr     = fr.minr;
  assign mid_in.distance = distance;
  assign mid_in.flags    = fr.flags;

  cpcr_div #(
    .LANES (3),
    .NUM_W (NUM_W),
    .DEN_W (TOTAL_W),
    .QUO_W (QW),
    .SW    ($bits(cpcr_mid_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_ready  (dv_in_ready),
    .in_num    (num),
    .in_den    (den),
    .in_side   (mid_in),
    .out_valid (dv_valid),
    .out_ready (bk_in_ready),
    .out_quo   (quo),
    .out_side  (mid_out)
  );

  // push, weighting and saturation; last stage is the output register
  cpcr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (dv_valid),
    .in_ready       (bk_in_ready),
    .in_nx          (quo[0]),
    .in_ny          (quo[1]),
    .in_share       (quo[2]),
    .in_side        (cpcr_mid_t'(mid_out)),
    .gain           (gain),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .move_a_x       (move_a_x),
    .move_a_y       (move_a_y),
    .move_b_x       (move_b_x),
    .move_b_y       (move_b_y),
    .contact_status (contact_status)
  );

`ifndef SYNTHESIS
  // no move unless the overlap was resolved
  a_no_move: assert property (@(posedge clk) disable iff (rst)
    out_valid && (contact_status != STATUS_HIT) |->
      (move_a_x == '0) && (move_a_y == '0) && (move_b_x == '0) && (move_b_y == '0))
    else $error("move on a pair that was not resolved");

  // the two bodies are never both pushed toward negative x
  a_opposite_x: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(move_a_x[MOVE_W-1] && move_b_x[MOVE_W-1]))
    else $error("both bodies pushed toward negative x");

  // the two bodies are never both pushed toward negative y
  a_opposite_y: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(move_a_y[MOVE_W-1] && move_b_y[MOVE_W-1]))
    else $error("both bodies pushed toward negative y");

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word valid after reset");
`endif

endmodule

>>> rtl/cpcr_sqrt.sv
// pipelined integer square root, one result bit per stage
// depends on cpcr_pkg
module cpcr_sqrt #(
  parameter int SW = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cpcr_pkg::DIST2_W-1:0] in_rad,
  input  logic [SW-1:0]               in_side,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cpcr_pkg::ROOT_W-1:0] out_root,
  output logic [SW-1:0]               out_side
);
  import cpcr_pkg::*;

  localparam int N = ROOT_W;

  logic [N-1:0]         vld;
  logic [N:0]           rdy;
  logic [DIST2_W-1:0]   rem_a  [N];
  logic [ROOT_W-1:0]    root_a [N];
  logic [SW-1:0]        side_a [N];

  assign rdy[N] = out_ready;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int BI = N - 1 - k;
    logic [DIST2_W-1:0] rem_in;
    logic [DIST2_W-1:0] test;
    logic [ROOT_W-1:0]  root_in;
    logic [SW-1:0]      side_in;
    logic               vld_in;
    logic               take;
    logic               v;
    logic [ROOT_W-1:0]  root;
    logic [SW-1:0]      side;

    if (k == 0) begin : g_first
      assign rem_in  = in_rad;
      assign root_in = '0;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_a[k-1];
      assign root_in = root_a[k-1];
      assign side_in = side_a[k-1];
      assign vld_in  = vld[k-1];
    end

    // (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i)
    assign test = ({{(DIST2_W-ROOT_W){1'b0}}, root_in} << (BI + 1)) |
                  (DIST2_W'(1) << (2 * BI));
    assign take = rem_in >= test;
    assign rdy[k] = !v || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v <= 1'b0;
      end else if (rdy[k]) begin
        v <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        root <= take ? (root_in | (ROOT_W'(1) << BI)) : root_in;
        side <= side_in;
      end
    end

    if (k < N - 1) begin : g_rem
      logic [DIST2_W-1:0] rem;
      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          rem <= take ? (rem_in - test) : rem_in;
        end
      end
      assign rem_a[k] = rem;
    end else begin : g_norem
      assign rem_a[k] = '0;
    end

    assign vld[k]    = v;
    assign root_a[k] = root;
    assign side_a[k] = side;
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[N-1];
  assign out_root  = root_a[N-1];
  assign out_side  = side_a[N-1];

endmodule

>>> rtl/cpcr_div.sv
// pipelined restoring divider, several lanes in lockstep, one quotient bit per stage
// depends on cpcr_pkg
module cpcr_div #(
  parameter int LANES = 3,
  parameter int NUM_W = 48,
  parameter int DEN_W = 33,
  parameter int QUO_W = 17,
  parameter int SW    = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [NUM_W-1:0] in_num [LANES],
  input  logic [DEN_W-1:0] in_den [LANES],
  input  logic [SW-1:0]    in_side,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [QUO_W-1:0] out_quo [LANES],
  output logic [SW-1:0]    out_side
);
  import cpcr_pkg::*;

  localparam int N  = QUO_W;
  localparam int CW = DEN_W + QUO_W;

  logic [N-1:0]     vld;
  logic [N:0]       rdy;
  logic [NUM_W-1:0] rem_a  [N][LANES];
  logic [DEN_W-1:0] den_a  [N][LANES];
  logic [QUO_W-1:0] quo_a  [N][LANES];
  logic [SW-1:0]    side_a [N];

  assign rdy[N] = out_ready;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int BI = N - 1 - k;
    logic          vld_in;
    logic          v;
    logic [SW-1:0] side_in;
    logic [SW-1:0] side;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld[k-1];
      assign side_in = side_a[k-1];
    end

    assign rdy[k] = !v || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v <= 1'b0;
      end else if (rdy[k]) begin
        v <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        side <= side_in;
      end
    end

    assign vld[k]    = v;
    assign side_a[k] = side;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [NUM_W-1:0] rem_in;
      logic [DEN_W-1:0] den_in;
      logic [QUO_W-1:0] quo_in;
      logic [CW:0]      diff;
      logic [QUO_W-1:0] quo;

      if (k == 0) begin : g_first
        assign rem_in = in_num[l];
        assign den_in = in_den[l];
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem_a[k-1][l];
        assign den_in = den_a[k-1][l];
        assign quo_in = quo_a[k-1][l];
      end

      // no borrow means the shifted divisor fits
      assign diff = {{(CW+1-NUM_W){1'b0}}, rem_in} -
                    ({{(CW+1-DEN_W){1'b0}}, den_in} << BI);

      always_ff @(posedge clk) begin
        if (rdy[k]) begin
          quo <= diff[CW] ? quo_in : (quo_in | (QUO_W'(1) << BI));
        end
      end
      assign quo_a[k][l] = quo;

      if (k < N - 1) begin : g_carry
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        always_ff @(posedge clk) begin
          if (rdy[k]) begin
            rem <= diff[CW] ? rem_in : diff[NUM_W-1:0];
            den <= den_in;
          end
        end
        assign rem_a[k][l] = rem;
        assign den_a[k][l] = den;
      end else begin : g_last
        assign rem_a[k][l] = '0;
        assign den_a[k][l] = '0;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[N-1];
  assign out_side  = side_a[N-1];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign out_quo[l] = quo_a[N-1][l];
  end

endmodule

>>> rtl/cpcr_back.sv
// scaling, push multiply and saturation, three stages ending in the output register
// depends on cpcr_pkg
module cpcr_back #(
  parameter int FRAC_BITS = cpcr_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [FRAC_BITS:0]            in_nx,
  input  logic [FRAC_BITS:0]            in_ny,
  input  logic [FRAC_BITS:0]            in_share,
  input  cpcr_pkg::cpcr_mid_t           in_side,
  input  logic [cpcr_pkg::GAIN_W-1:0]   gain,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [cpcr_pkg::MOVE_W-1:0] move_a_x,
  output logic signed [cpcr_pkg::MOVE_W-1:0] move_a_y,
  output logic signed [cpcr_pkg::MOVE_W-1:0] move_b_x,
  output logic signed [cpcr_pkg::MOVE_W-1:0] move_b_y,
  output logic [1:0]                    contact_status
);
  import cpcr_pkg::*;

  localparam int QW  = FRAC_BITS + 1;
  localparam int PW  = SUM_W + GAIN_W;
  localparam int TW  = 2 * QW;
  localparam int MW  = QW + SUM_W;
  localparam int MAG = MOVE_W + 1;

  function automatic logic [MOVE_W-1:0] sat_move(input logic [MAG-1:0] mag, input logic neg);
    logic [MAG-1:0] lim;
    begin
      lim = neg ? (MAG'(1) << (MOVE_W - 1)) : ((MAG'(1) << (MOVE_W - 1)) - MAG'(1));
      if (mag > lim) begin
        mag = lim;
      end
      sat_move = neg ? (MOVE_W'(0) - mag[MOVE_W-1:0]) : mag[MOVE_W-1:0];
    end
  endfunction

  logic [2:0] vld;
  logic [3:0] rdy;

  logic [QW-1:0]    share_b;
  logic [PW-1:0]    push_p;
  logic [TW-1:0]    t_ax, t_ay, t_bx, t_by;
  cpcr_flags_t      flags1, flags2;
  logic [MW-1:0]    m_ax_p, m_ay_p, m_bx_p, m_by_p;
  logic [MAG-1:0]   m_ax, m_ay, m_bx, m_by;
  logic [SUM_W-1:0] push;

  assign rdy[3] = out_ready;
  assign rdy[2] = !vld[2] || rdy[3];
  assign rdy[1] = !vld[1] || rdy[2];
  assign rdy[0] = !vld[0] || rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
    end
  end

  assign share_b = (QW'(1) << FRAC_BITS) - in_share;

  // stage 1: direction times share, penetration times gain
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      push_p <= PW'(in_side.minr - in_side.distance) * PW'(gain);
      t_ax   <= TW'(in_nx) * TW'(in_share);
      t_ay   <= TW'(in_ny) * TW'(in_share);
      t_bx   <= TW'(in_nx) * TW'(share_b);
      t_by   <= TW'(in_ny) * TW'(share_b);
      flags1 <= in_side.flags;
    end
  end

  assign push = push_p[PW-1:GAIN_W];

  // stage 2: scaled direction times push
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      m_ax_p <= MW'(t_ax[QW+FRAC_BITS-1:FRAC_BITS]) * MW'(push);
      m_ay_p <= MW'(t_ay[QW+FRAC_BITS-1:FRAC_BITS]) * MW'(push);
      m_bx_p <= MW'(t_bx[QW+FRAC_BITS-1:FRAC_BITS]) * MW'(push);
      m_by_p <= MW'(t_by[QW+FRAC_BITS-1:FRAC_BITS]) * MW'(push);
      flags2 <= flags1;
    end
  end

  assign m_ax = m_ax_p[MW-1:FRAC_BITS];
  assign m_ay = m_ay_p[MW-1:FRAC_BITS];
  assign m_bx = m_bx_p[MW-1:FRAC_BITS];
  assign m_by = m_by_p[MW-1:FRAC_BITS];

  // stage 3: sign, saturation, status select
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      contact_status <= flags2.status;
      if (flags2.status == STATUS_HIT) begin
        move_a_x <= sat_move(m_ax, flags2.dx_neg);
        move_a_y <= sat_move(m_ay, flags2.dy_neg);
        move_b_x <= sat_move(m_bx, flags2.dx_pos);
        move_b_y <= sat_move(m_by, flags2.dy_pos);
      end else begin
        move_a_x <= '0;
        move_a_y <= '0;
        move_b_x <= '0;
        move_b_y <= '0;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[2];

endmodule
